FILE: rtl/core/rola_pkg.sv
`timescale 1ns / 1ps

package rola_pkg;

  // Event operation codes
  localparam logic [3:0] OP_INIT          = 4'd0;
  localparam logic [3:0] OP_HOLD_FREEZE   = 4'd1;
  localparam logic [3:0] OP_CLEAR_FREEZE  = 4'd2;
  localparam logic [3:0] OP_BUMP_WATCH    = 4'd3;
  localparam logic [3:0] OP_BUMP_WATCH_DF = 4'd4;
  localparam logic [3:0] OP_WATCH_OFF     = 4'd5;
  localparam logic [3:0] OP_SET_SESSION   = 4'd6;
  localparam logic [3:0] OP_SET_TLS       = 4'd7;
  localparam logic [3:0] OP_TRY_BEGIN     = 4'd8;
  localparam logic [3:0] OP_END_NET       = 4'd9;
  localparam logic [3:0] OP_BEGIN_HEAVY   = 4'd10;
  localparam logic [3:0] OP_BEGIN_HEAVY_DF = 4'd11;
  localparam logic [3:0] OP_END_HEAVY     = 4'd12;
  localparam logic [3:0] OP_TICK          = 4'd13;
  localparam logic [3:0] OP_STATUS        = 4'd14;

  // Owner codes
  localparam logic [1:0] OWN_NONE = 2'd0;
  localparam logic [1:0] OWN_NET  = 2'd1;
  localparam logic [1:0] OWN_UI   = 2'd2;

  // Hold limits in ms
  localparam logic [31:0] FREEZE_MAX_MS  = 32'd15000;
  localparam logic [31:0] WATCH_MIN_MS   = 32'd1000;
  localparam logic [31:0] HEAVY_MIN_MS   = 32'd200;
  localparam logic [31:0] WATCH_GRACE_MS = 32'd15 * 32'd1000;

  // Register reset values
  localparam logic [31:0] WATCH_DEFAULT_RST = 32'd60000;
  localparam logic [31:0] HEAVY_DEFAULT_RST = 32'd2500;

  // Register indexes
  localparam logic REG_WATCH_DEFAULT = 1'b0;
  localparam logic REG_HEAVY_DEFAULT = 1'b1;

  typedef struct packed {
    logic [1:0]  owner;
    logic        session;
    logic        tls;
    logic        watch_off;
    logic [31:0] watch_dl;
    logic [31:0] heavy_dl;
    logic [31:0] freeze_dl;
    logic        light;
    logic        frozen;
  } state_t;

  typedef struct packed {
    logic [1:0] owner;
    logic       granted;
    logic       net_wanted;
    logic       net_allowed;
    logic       link_busy;
    logic       session_on;
    logic       tls_on;
    logic       display_light;
    logic       display_frozen;
  } result_t;

  // a lies strictly later than b, modulo 2^32
  function automatic logic is_later(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && !d[31];
  endfunction

endpackage

FILE: rtl/core/rola_event.sv
`timescale 1ns / 1ps

module rola_event import rola_pkg::*; (
  input  state_t      st,
  input  logic [3:0]  operation,
  input  logic [31:0] now_ms,
  input  logic [31:0] hold_ms,
  input  logic        flag,
  input  logic [31:0] watch_default_ms,
  input  logic [31:0] ui_heavy_default_ms,
  output state_t      st_next,
  output result_t     res
);

  logic [31:0] freeze_hold;
  logic [31:0] watch_raw;
  logic [31:0] watch_hold;
  logic [31:0] heavy_raw;
  logic [31:0] heavy_hold;
  logic [31:0] freeze_until;
  logic [31:0] watch_until;
  logic [31:0] heavy_until;
  logic        heavy_before;
  logic        heavy_after;
  logic        granted;
  logic        recompute;

  always_comb begin
    freeze_hold  = (hold_ms > FREEZE_MAX_MS) ? FREEZE_MAX_MS : hold_ms;
    watch_raw    = (operation == OP_BUMP_WATCH_DF) ? watch_default_ms : hold_ms;
    watch_hold   = (watch_raw < WATCH_MIN_MS) ? WATCH_MIN_MS : watch_raw;
    heavy_raw    = (operation == OP_BEGIN_HEAVY_DF) ? ui_heavy_default_ms : hold_ms;
    heavy_hold   = (heavy_raw < HEAVY_MIN_MS) ? HEAVY_MIN_MS : heavy_raw;
    freeze_until = now_ms + freeze_hold;
    watch_until  = now_ms + watch_hold;
    heavy_until  = now_ms + heavy_hold;
    heavy_before = is_later(st.heavy_dl, now_ms);
  end

  always_comb begin
    st_next   = st;
    granted   = 1'b0;
    recompute = 1'b0;
    case (operation)
      OP_INIT: begin
        st_next = '0;
      end
      OP_HOLD_FREEZE: begin
        if (is_later(freeze_until, st.freeze_dl)) st_next.freeze_dl = freeze_until;
        recompute = 1'b1;
      end
      OP_CLEAR_FREEZE: begin
        st_next.freeze_dl = 32'd0;
        recompute = 1'b1;
      end
      OP_BUMP_WATCH, OP_BUMP_WATCH_DF: begin
        st_next.watch_off = 1'b0;
        if (is_later(watch_until, st.watch_dl)) st_next.watch_dl = watch_until;
      end
      OP_WATCH_OFF: begin
        st_next.watch_off = 1'b1;
        st_next.watch_dl  = now_ms + WATCH_GRACE_MS;
      end
      OP_SET_SESSION: begin
        st_next.session = flag;
        if (flag) begin
          st_next.owner = OWN_NET;
        end else if (st.owner == OWN_NET && !st.tls) begin
          st_next.owner = OWN_NONE;
        end
        recompute = 1'b1;
      end
      OP_SET_TLS: begin
        st_next.tls = flag;
        if (flag) st_next.owner = OWN_NET;
        recompute = 1'b1;
      end
      OP_TRY_BEGIN: begin
        if (!(heavy_before && !st.session && !st.tls)) begin
          st_next.owner = OWN_NET;
          granted   = 1'b1;
          recompute = 1'b1;
        end
      end
      OP_END_NET: begin
        if (!st.session && !st.tls) st_next.owner = OWN_NONE;
        recompute = 1'b1;
      end
      OP_BEGIN_HEAVY, OP_BEGIN_HEAVY_DF: begin
        if (is_later(heavy_until, st.heavy_dl)) st_next.heavy_dl = heavy_until;
        recompute = 1'b1;
      end
      OP_END_HEAVY: begin
        st_next.heavy_dl = 32'd0;
        recompute = 1'b1;
      end
      OP_TICK: begin
        if (!heavy_before && st.owner == OWN_UI) st_next.owner = OWN_NONE;
        recompute = 1'b1;
      end
      default: begin
        // status and unused code: no change
      end
    endcase

    heavy_after = is_later(st_next.heavy_dl, now_ms);
    if (recompute) begin
      st_next.light  = st_next.tls || heavy_after;
      st_next.frozen = st_next.tls || is_later(st_next.freeze_dl, now_ms);
    end

    res.owner          = st_next.owner;
    res.granted        = granted;
    res.net_wanted     = !st_next.watch_off && is_later(st_next.watch_dl, now_ms);
    res.net_allowed    = !heavy_after;
    res.link_busy      = st_next.tls || st_next.session || heavy_after ||
                         (st_next.owner != OWN_NONE);
    res.session_on     = st_next.session;
    res.tls_on         = st_next.tls;
    res.display_light  = st_next.light;
    res.display_frozen = st_next.frozen;
  end

endmodule

FILE: rtl/core/radio_owner_lease_arbiter.sv
`timescale 1ns / 1ps

// Radio owner lease arbiter. Each event transfer (operation, now_ms, hold_ms,
// flag) updates who owns the shared radio link (none, network, UI), the
// session and TLS flags, and three wrap-safe deadlines (watch, UI-heavy,
// freeze), and returns exactly one status transfer taken after the event.
// Rate: one event per cycle sustained while the status side does not stall. An
// accepted event is held in the input register, is evaluated by a single
// combinational pass (a few 32-bit adds and wrap-safe compares against the held
// state) and lands in the result register, which drives the status outputs.
// The held state is written at the same edge as the result, so the next
// event in the input register already sees it. The input side stalls only
// while the input register is full and the result register is full and
// stalled. Registers: watch_default_ms at 0x0, ui_heavy_default_ms at 0x4;
// write them only while no event is in flight.
module radio_owner_lease_arbiter import rola_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // APB register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // event channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  operation,
  input  logic [31:0] now_ms,
  input  logic [31:0] hold_ms,
  input  logic        flag,
  // status channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  owner,
  output logic        granted,
  output logic        net_wanted,
  output logic        net_allowed,
  output logic        link_busy,
  output logic        session_on,
  output logic        tls_on,
  output logic        display_light,
  output logic        display_frozen
);

  // configuration registers
  logic [31:0] watch_default_ms;
  logic [31:0] ui_heavy_default_ms;
  logic        cfg_write;

  // input register
  logic        s1_valid;
  logic [3:0]  s1_operation;
  logic [31:0] s1_now_ms;
  logic [31:0] s1_hold_ms;
  logic        s1_flag;

  // arbiter state and result register
  state_t      state;
  state_t      state_next;
  result_t     res_next;
  result_t     res;

  logic        in_take;
  logic        advance;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign prdata    = (paddr[2] == REG_HEAVY_DEFAULT) ? ui_heavy_default_ms : watch_default_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      watch_default_ms    <= WATCH_DEFAULT_RST;
      ui_heavy_default_ms <= HEAVY_DEFAULT_RST;
    end else if (cfg_write) begin
      if (paddr[2] == REG_WATCH_DEFAULT) watch_default_ms <= pwdata;
      else                               ui_heavy_default_ms <= pwdata;
    end
  end

  // Evaluate the held event when the result register is free or draining.
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_operation <= operation;
      s1_now_ms    <= now_ms;
      s1_hold_ms   <= hold_ms;
      s1_flag      <= flag;
    end
  end

  rola_event u_event (
    .st                  (state),
    .operation           (s1_operation),
    .now_ms              (s1_now_ms),
    .hold_ms             (s1_hold_ms),
    .flag                (s1_flag),
    .watch_default_ms    (watch_default_ms),
    .ui_heavy_default_ms (ui_heavy_default_ms),
    .st_next             (state_next),
    .res                 (res_next)
  );

  // State commits together with the result transfer it produced.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) res <= res_next;
  end

  assign owner          = res.owner;
  assign granted        = res.granted;
  assign net_wanted     = res.net_wanted;
  assign net_allowed    = res.net_allowed;
  assign link_busy      = res.link_busy;
  assign session_on     = res.session_on;
  assign tls_on         = res.tls_on;
  assign display_light  = res.display_light;
  assign display_frozen = res.display_frozen;

  // A grant always leaves the network as owner.
  a_grant_owner: assert property (@(posedge clk) disable iff (rst)
    (out_valid && granted) |-> (owner == OWN_NET))
    else $error("grant without network owner");

  // An active UI-heavy deadline always shows as a busy link.
  a_heavy_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !net_allowed) |-> link_busy)
    else $error("heavy active but link not busy");

  // TLS busy forces both display modes on.
  a_tls_display: assert property (@(posedge clk) disable iff (rst)
    (out_valid && tls_on) |-> (display_light && display_frozen))
    else $error("tls on without display modes");

  // Input stalls only when both registers are occupied.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && out_valid && out_stall))
    else $error("input stalled without back pressure");

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

// Testbench for radio_owner_lease_arbiter.
// Event transfers go in through a valid/stall driver fed from a queue. Each accepted
// event runs through a local lease model, and the expected status goes into a FIFO.
// Status transfers are checked field by field against that FIFO.
module tb_top import rola_pkg::*; ();

  // op code 15 has no name in the package: the block treats it as status
  localparam logic [3:0] OP_SPARE = 4'd15;
  localparam int QUIET_LIMIT = 4000;   // cycles without any transfer before giving up

  typedef struct packed {
    logic [3:0]  op;
    logic [31:0] now;
    logic [31:0] hold;
    logic        fl;
  } lease_ev_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  operation = '0;
  logic [31:0] now_ms = '0, hold_ms = '0;
  logic        flag = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  owner;
  logic        granted, net_wanted, net_allowed, link_busy;
  logic        session_on, tls_on, display_light, display_frozen;

  radio_owner_lease_arbiter dut (
    .clk, .rst,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_stall, .operation, .now_ms, .hold_ms, .flag,
    .out_valid, .out_stall, .owner, .granted, .net_wanted, .net_allowed,
    .link_busy, .session_on, .tls_on, .display_light, .display_frozen
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Lease model: own copy of the arbiter state and of the two default registers
  // ---------------------------------------------------------------------------
  logic [1:0]  m_owner;
  logic        m_session, m_tls, m_wforced, m_light, m_frozen;
  logic [31:0] m_watch_dl, m_heavy_dl, m_freeze_dl;
  logic [31:0] cfg_watch_df = WATCH_DEFAULT_RST;
  logic [31:0] cfg_heavy_df = HEAVY_DEFAULT_RST;

  // wrap-safe "a strictly after b": difference is nonzero and in the lower half
  function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] d;
    d = a - b;
    return (d != 32'd0) && (d < 32'h8000_0000);
  endfunction

  // deadlines only ever move later
  function automatic logic [31:0] push_later(input logic [31:0] old, input logic [31:0] cand);
    return later_than(cand, old) ? cand : old;
  endfunction

  function automatic void clear_model();
    m_owner     = OWN_NONE;
    m_session   = 1'b0;
    m_tls       = 1'b0;
    m_wforced   = 1'b0;
    m_watch_dl  = '0;
    m_heavy_dl  = '0;
    m_freeze_dl = '0;
    m_light     = 1'b0;
    m_frozen    = 1'b0;
  endfunction

  function automatic void refresh_display(input logic [31:0] now);
    m_light  = m_tls || later_than(m_heavy_dl, now);
    m_frozen = m_tls || later_than(m_freeze_dl, now);
  endfunction

  // applies one event to the model and returns the status it must produce
  function automatic result_t lease_status(input lease_ev_t e);
    result_t     r;
    logic [31:0] h;
    logic        heavy_on;
    r = '0;
    h = e.hold;
    case (e.op)
      OP_INIT: clear_model();
      OP_HOLD_FREEZE: begin
        if (h > FREEZE_MAX_MS) h = FREEZE_MAX_MS;
        m_freeze_dl = push_later(m_freeze_dl, e.now + h);
        refresh_display(e.now);
      end
      OP_CLEAR_FREEZE: begin
        m_freeze_dl = '0;
        refresh_display(e.now);
      end
      OP_BUMP_WATCH, OP_BUMP_WATCH_DF: begin
        // watch bumps leave the display alone
        if (e.op == OP_BUMP_WATCH_DF) h = cfg_watch_df;
        if (h < WATCH_MIN_MS) h = WATCH_MIN_MS;
        m_wforced  = 1'b0;
        m_watch_dl = push_later(m_watch_dl, e.now + h);
      end
      OP_WATCH_OFF: begin
        m_wforced  = 1'b1;
        m_watch_dl = e.now + WATCH_GRACE_MS;
      end
      OP_SET_SESSION: begin
        m_session = e.fl;
        if (e.fl) m_owner = OWN_NET;
        else if (m_owner == OWN_NET && !m_tls) m_owner = OWN_NONE;
        refresh_display(e.now);
      end
      OP_SET_TLS: begin
        m_tls = e.fl;
        if (e.fl) m_owner = OWN_NET;
        refresh_display(e.now);
      end
      OP_TRY_BEGIN: begin
        // refused while UI-heavy runs with no session and no TLS
        if (!(later_than(m_heavy_dl, e.now) && !m_session && !m_tls)) begin
          m_owner   = OWN_NET;
          r.granted = 1'b1;
          refresh_display(e.now);
        end
      end
      OP_END_NET: begin
        if (!m_session && !m_tls) m_owner = OWN_NONE;
        refresh_display(e.now);
      end
      OP_BEGIN_HEAVY, OP_BEGIN_HEAVY_DF: begin
        if (e.op == OP_BEGIN_HEAVY_DF) h = cfg_heavy_df;
        if (h < HEAVY_MIN_MS) h = HEAVY_MIN_MS;
        m_heavy_dl = push_later(m_heavy_dl, e.now + h);
        refresh_display(e.now);
      end
      OP_END_HEAVY: begin
        m_heavy_dl = '0;
        refresh_display(e.now);
      end
      OP_TICK: begin
        if (!later_than(m_heavy_dl, e.now) && m_owner == OWN_UI) m_owner = OWN_NONE;
        refresh_display(e.now);
      end
      default: ;  // status and the spare code change nothing
    endcase
    heavy_on         = later_than(m_heavy_dl, e.now);
    r.owner          = m_owner;
    r.net_wanted     = !m_wforced && later_than(m_watch_dl, e.now);
    r.net_allowed    = !heavy_on;
    r.link_busy      = m_tls || m_session || heavy_on || (m_owner != OWN_NONE);
    r.session_on     = m_session;
    r.tls_on         = m_tls;
    r.display_light  = m_light;
    r.display_frozen = m_frozen;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Bookkeeping
  // ---------------------------------------------------------------------------
  lease_ev_t pend_q[$];        // events waiting for the driver
  result_t   status_q[$];      // expected status, oldest first
  int        events_queued = 0;
  int        events_taken  = 0;
  int        err_cnt       = 0;
  int        quiet         = 0;
  int        send_idle_pct = 0;
  int        recv_idle_pct = 0;
  logic      ev_took       = 1'b0;
  logic [31:0] t_cur       = '0;

  task automatic note_bad(input string what, input logic [31:0] got, input logic [31:0] want);
    err_cnt++;
    $display("mismatch %s: got %0h want %0h (event %0d)", what, got, want, events_taken);
  endtask

  task automatic check_status(input result_t got, input result_t want);
    if (got.owner != want.owner)
      note_bad("owner", 32'(got.owner), 32'(want.owner));
    if (got.granted != want.granted)
      note_bad("granted", 32'(got.granted), 32'(want.granted));
    if (got.net_wanted != want.net_wanted)
      note_bad("net_wanted", 32'(got.net_wanted), 32'(want.net_wanted));
    if (got.net_allowed != want.net_allowed)
      note_bad("net_allowed", 32'(got.net_allowed), 32'(want.net_allowed));
    if (got.link_busy != want.link_busy)
      note_bad("link_busy", 32'(got.link_busy), 32'(want.link_busy));
    if (got.session_on != want.session_on)
      note_bad("session_on", 32'(got.session_on), 32'(want.session_on));
    if (got.tls_on != want.tls_on)
      note_bad("tls_on", 32'(got.tls_on), 32'(want.tls_on));
    if (got.display_light != want.display_light)
      note_bad("display_light", 32'(got.display_light), 32'(want.display_light));
    if (got.display_frozen != want.display_frozen)
      note_bad("display_frozen", 32'(got.display_frozen), 32'(want.display_frozen));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: one new event per falling edge at most; a stalled transfer holds
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin : ev_drive
    lease_ev_t nx;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_valid && !ev_took) begin
      // previous transfer not taken yet: keep valid and payload
    end else if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
      nx = pend_q.pop_front();
      in_valid  <= 1'b1;
      operation <= nx.op;
      now_ms    <= nx.now;
      hold_ms   <= nx.hold;
      flag      <= nx.fl;
    end else begin
      in_valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : st_drive
    if (rst) out_stall <= 1'b0;
    else     out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // ---------------------------------------------------------------------------
  // Monitor, model update and watchdog, all on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    result_t   got;
    lease_ev_t e;
    if (rst) begin
      ev_took = 1'b0;
      quiet   = 0;
      clear_model();
    end else begin
      ev_took = in_valid && !in_stall;
      // status first: an event taken at this edge cannot already be answered
      if (out_valid && !out_stall) begin
        got.owner          = owner;
        got.granted        = granted;
        got.net_wanted     = net_wanted;
        got.net_allowed    = net_allowed;
        got.link_busy      = link_busy;
        got.session_on     = session_on;
        got.tls_on         = tls_on;
        got.display_light  = display_light;
        got.display_frozen = display_frozen;
        if (status_q.size() == 0) note_bad("status with nothing expected", 32'(got), '0);
        else check_status(got, status_q.pop_front());
      end
      if (ev_took) begin
        e.op   = operation;
        e.now  = now_ms;
        e.hold = hold_ms;
        e.fl   = flag;
        status_q.push_back(lease_status(e));
        events_taken++;
      end
      if (ev_took || (out_valid && !out_stall) || psel) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic queue_ev(input logic [3:0] op, input logic [31:0] now,
                          input logic [31:0] hold, input logic fl);
    lease_ev_t e;
    e.op = op; e.now = now; e.hold = hold; e.fl = fl;
    pend_q.push_back(e);
    events_queued++;
  endtask

  // time mostly moves forward in small steps so deadlines expire inside the run,
  // with occasional jumps to the wrap point or anywhere at all
  function automatic logic [31:0] step_now();
    int r;
    r = $urandom_range(99);
    if (r < 10)      ;
    else if (r < 50) t_cur = t_cur + $urandom_range(1, 300);
    else if (r < 80) t_cur = t_cur + $urandom_range(300, 3000);
    else if (r < 92) t_cur = t_cur + $urandom_range(3000, 70000);
    else if (r < 96) t_cur = 32'hFFFF_FFFF - $urandom_range(0, 5000);
    else             t_cur = $urandom();
    return t_cur;
  endfunction

  function automatic logic [31:0] pick_hold();
    logic [31:0] edges [10] = '{0, 199, 200, 201, 999, 1000, 1001, 14999, 15000, 15001};
    logic [31:0] tops  [3]  = '{32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
    int r;
    r = $urandom_range(99);
    if (r < 15) return edges[$urandom_range(9)];
    if (r < 55) return $urandom_range(0, 3000);
    if (r < 85) return $urandom_range(0, 70000);
    if (r < 93) return $urandom();
    return tops[$urandom_range(2)];
  endfunction

  task automatic queue_random(input int n);
    int k, r;
    logic [3:0] op;
    k = 0;
    while (k < n) begin
      r = $urandom_range(99);
      if (r < 35) begin
        // short sequences that exercise arbitration against live deadlines
        case ($urandom_range(3))
          0: begin
            queue_ev(OP_BEGIN_HEAVY, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_TRY_BEGIN, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_SET_SESSION, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_TRY_BEGIN, step_now(), pick_hold(), 1'($urandom_range(1)));
          end
          1: begin
            queue_ev(OP_HOLD_FREEZE, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_SET_TLS, step_now(), pick_hold(), 1'b1);
            queue_ev(OP_TICK, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_SET_TLS, step_now(), pick_hold(), 1'b0);
          end
          2: begin
            queue_ev(OP_WATCH_OFF, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_STATUS, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_BUMP_WATCH, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_BUMP_WATCH_DF, step_now(), pick_hold(), 1'($urandom_range(1)));
          end
          default: begin
            queue_ev(OP_BEGIN_HEAVY_DF, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_TRY_BEGIN, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_END_NET, step_now(), pick_hold(), 1'($urandom_range(1)));
            queue_ev(OP_END_HEAVY, step_now(), pick_hold(), 1'($urandom_range(1)));
          end
        endcase
        k += 4;
      end else begin
        // lone events; init is kept rare since it wipes the state
        if (r < 37)      op = OP_INIT;
        else if (r < 40) op = OP_SPARE;
        else             op = 4'($urandom_range(1, 14));
        queue_ev(op, step_now(), pick_hold(), 1'($urandom_range(1)));
        k++;
      end
    end
  endtask

  // hold off new events until every status transfer is back
  task automatic drain();
    while (events_taken != events_queued || status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // APB write followed by a read-back; only called with no event in flight
  task automatic reg_set(input logic idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0; pwrite <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) note_bad("prdata", prdata, val);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0;
    if (idx == REG_WATCH_DEFAULT) cfg_watch_df = val;
    else                          cfg_heavy_df = val;
  endtask

  // ---------------------------------------------------------------------------
  // Run plan
  // ---------------------------------------------------------------------------
  initial begin : plan
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 31;
    recv_idle_pct = 57;

    // directed: reset defaults, clamps, refusal, wrap, spare code
    queue_ev(OP_INIT,           32'd0,          32'd0,          1'b0);
    queue_ev(OP_STATUS,         32'd0,          32'd0,          1'b1);
    queue_ev(OP_HOLD_FREEZE,    32'd0,          32'hFFFF_FFFF,  1'b0);  // clamps to max
    queue_ev(OP_STATUS,         32'd14999,      32'd0,          1'b0);
    queue_ev(OP_TICK,           32'd15000,      32'd0,          1'b0);  // freeze just expired
    queue_ev(OP_BUMP_WATCH,     32'd100,        32'd5,          1'b0);  // clamps to minimum
    queue_ev(OP_BUMP_WATCH_DF,  32'd200,        32'd0,          1'b1);
    queue_ev(OP_WATCH_OFF,      32'd300,        32'd0,          1'b0);
    queue_ev(OP_STATUS,         32'd15300,      32'd0,          1'b0);  // grace ends exactly now
    queue_ev(OP_BEGIN_HEAVY,    32'd400,        32'd0,          1'b0);  // clamps to minimum
    queue_ev(OP_TRY_BEGIN,      32'd500,        32'd0,          1'b0);  // refused
    queue_ev(OP_BEGIN_HEAVY_DF, 32'd600,        32'd0,          1'b1);
    queue_ev(OP_SET_TLS,        32'd700,        32'd0,          1'b1);
    queue_ev(OP_TRY_BEGIN,      32'd800,        32'd0,          1'b0);  // granted through tls
    queue_ev(OP_SET_TLS,        32'd900,        32'd0,          1'b0);
    queue_ev(OP_SET_SESSION,    32'd1000,       32'd0,          1'b1);
    queue_ev(OP_SET_SESSION,    32'd1100,       32'd0,          1'b0);
    queue_ev(OP_END_NET,        32'd1200,       32'd0,          1'b0);
    queue_ev(OP_END_HEAVY,      32'd1300,       32'd0,          1'b0);
    queue_ev(OP_CLEAR_FREEZE,   32'd1400,       32'd0,          1'b0);
    queue_ev(OP_SPARE,          32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
    queue_ev(OP_HOLD_FREEZE,    32'hFFFF_FF00,  32'd1000,       1'b0);  // deadline wraps
    queue_ev(OP_TICK,           32'h0000_0010,  32'd0,          1'b1);
    queue_ev(OP_INIT,           32'hFFFF_FFFF,  32'hFFFF_FFFF,  1'b1);
    queue_ev(OP_STATUS,         32'hFFFF_FFFF,  32'd0,          1'b0);
    drain();

    // extreme defaults: watch at zero clamps to its minimum, heavy at the largest value
    reg_set(REG_WATCH_DEFAULT, 32'd0);
    reg_set(REG_HEAVY_DEFAULT, 32'hFFFF_FFFF);
    t_cur = $urandom_range(0, 100000);
    queue_random(135);
    drain();  // sender waits here for every status to return
    queue_random(135);
    drain();

    send_idle_pct = 57;
    recv_idle_pct = 31;
    reg_set(REG_WATCH_DEFAULT, 32'hFFFF_FFFF);
    reg_set(REG_HEAVY_DEFAULT, 32'd0);
    t_cur = 32'hFFFF_0000;
    queue_random(270);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    reg_set(REG_WATCH_DEFAULT, $urandom_range(0, 5000));
    reg_set(REG_HEAVY_DEFAULT, $urandom_range(0, 5000));
    queue_random(270);
    drain();

    repeat (8) @(negedge clk);
    if (status_q.size() != 0) note_bad("status never returned", 32'(status_q.size()), '0);
    if (err_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/rola_pkg.sv
rtl/core/rola_event.sv
rtl/core/radio_owner_lease_arbiter.sv
bench/tb_top.sv
